// ===== rtl/pfel_pkg.sv =====
// ----------------------------------------------------------------------------
// pfel_pkg
// Shared types and constants of the pulse frame edge locator.
// ----------------------------------------------------------------------------
package pfel_pkg;

	// stream and config port widths
	localparam int SYM_W       = 32;
	localparam int NOW_W       = 63;
	localparam int S_TDATA_W   = 96;
	localparam int M_TDATA_W   = 128;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	// symbol layout
	localparam int DUR_W       = 15;
	localparam int TICK_W      = 16;
	localparam int PROD_W      = DUR_W + TICK_W;
	localparam int DSUM_W      = PROD_W + 1;
	localparam int ACC_W       = 64;

	localparam int WIDTH_W     = 32;
	localparam int LIMIT_W     = 24;
	localparam int AGE_LIM_W   = 32;
	localparam int ODD_W       = 32;

	// reset values of the config registers
	localparam logic [TICK_W-1:0]    TICK_NS_RST   = 16'd1000;
	localparam logic [LIMIT_W-1:0]   MIN_WIDTH_RST = 24'd10000;
	localparam logic [LIMIT_W-1:0]   MAX_WIDTH_RST = 24'd500000;
	localparam logic [AGE_LIM_W-1:0] MAX_AGE_RST   = 32'd1500000;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_NS      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH_US = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH_US = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE_US   = 2'd3;

	// divide by 1000: 16-bit digits, reciprocal multiply then remainder per digit
	localparam int DIGIT_W     = 16;
	localparam int NDIGITS     = ACC_W / DIGIT_W;
	localparam int DIV_STAGES  = 2 * NDIGITS;
	localparam int REM_W       = 10;
	localparam int DV_W        = REM_W + DIGIT_W;
	localparam int RECIP_W     = 27;
	localparam int DPROD_W     = DV_W + RECIP_W;
	localparam int RECIP_SHIFT = 36;
	localparam logic [RECIP_W-1:0] RECIP_1000 = 27'd68719477;
	localparam logic [DV_W-1:0]    DIVISOR    = 26'd1000;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_EDGE   = 2'd1,
		ST_BAD_WIDTH = 2'd2,
		ST_TOO_OLD   = 2'd3
	} status_t;

endpackage

// ===== rtl/pfel_div1000.sv =====
// ----------------------------------------------------------------------------
// pfel_div1000
// Pipelined unsigned divide of a 64-bit value by 1000, one 16-bit digit per
// pair of stages: reciprocal multiply, then remainder.
// ----------------------------------------------------------------------------
module pfel_div1000 (
	input  logic                                clk,
	input  logic [pfel_pkg::DIV_STAGES-1:0]     adv,  // stage load enables
	input  logic [pfel_pkg::ACC_W-1:0]          x,
	output logic [pfel_pkg::ACC_W-1:0]          q
);
	import pfel_pkg::*;

	logic [DV_W-1:0]    a_v_q   [NDIGITS];
	logic [DIGIT_W-1:0] a_d_q   [NDIGITS];
	logic [ACC_W-1:0]   a_x_q   [NDIGITS];
	logic [ACC_W-1:0]   a_quo_q [NDIGITS];
	logic [REM_W-1:0]   b_rem_q [NDIGITS];
	logic [ACC_W-1:0]   b_x_q   [NDIGITS];
	logic [ACC_W-1:0]   b_quo_q [NDIGITS];

	for (genvar k = 0; k < NDIGITS; k++) begin : g_digit
		logic [REM_W-1:0]   src_rem;
		logic [ACC_W-1:0]   src_x;
		logic [ACC_W-1:0]   src_quo;
		logic [DV_W-1:0]    v;
		logic [DPROD_W-1:0] prod;
		logic [DV_W-1:0]    rem_full;
		logic [ACC_W-1:0]   quo_ins;

		if (k == 0) begin : g_first
			assign src_rem = '0;
			assign src_x   = x;
			assign src_quo = '0;
		end else begin : g_next
			assign src_rem = b_rem_q[k-1];
			assign src_x   = b_x_q[k-1];
			assign src_quo = b_quo_q[k-1];
		end

		assign v    = {src_rem, src_x[ACC_W-1-DIGIT_W*k -: DIGIT_W]};
		assign prod = DPROD_W'(v) * DPROD_W'(RECIP_1000);

		// exact for every v below 1000 * 2^16
		always_ff @(posedge clk) begin
			if (adv[2*k]) begin
				a_v_q[k]   <= v;
				a_d_q[k]   <= prod[RECIP_SHIFT +: DIGIT_W];
				a_x_q[k]   <= src_x;
				a_quo_q[k] <= src_quo;
			end
		end

		assign rem_full = a_v_q[k] - DV_W'(a_d_q[k]) * DIVISOR;
		assign quo_ins  = a_quo_q[k] | (ACC_W'(a_d_q[k]) << (ACC_W - DIGIT_W*(k+1)));

		always_ff @(posedge clk) begin
			if (adv[2*k+1]) begin
				b_rem_q[k] <= rem_full[REM_W-1:0];
				b_x_q[k]   <= a_x_q[k];
				b_quo_q[k] <= quo_ins;
			end
		end
	end

	assign q = b_quo_q[NDIGITS-1];

endmodule

// ===== rtl/pulse_frame_edge_locator_core.sv =====
// ----------------------------------------------------------------------------
// pulse_frame_edge_locator_core
// Finds the last rising edge in a frame of run-length capture symbols and
// reports its time, the pulse width and a plausibility status per frame.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one capture symbol per transaction; tlast marks the last
//   symbol of a frame and only that transaction yields a result. now_us is
//   sampled with the tlast transaction.
//   Master stream: one result per frame, status in tuser.
//   Config channel: cfg_index selects the register, cfg_data is truncated to
//   its width; write only while the block holds no frame in flight.
// Pipeline: the product stage loads with the tlast transaction, then the
//   accumulate, age subtract, 8 divider stages and the result register
//   follow in turn before a result is presented.
// Throughput: one symbol per cycle while s_tready is high; the accumulators
//   update elapsed, rise and high times from both halves of a symbol at once.
// Reset: per-frame accumulators and the odd pulse count clear, config
//   registers return to their defaults, all stages empty.
// Stall: a result waits in the output register while m_tready is low; the
//   stages behind it keep filling bubbles and s_tready drops only once every
//   stage holds an item.
// ----------------------------------------------------------------------------
module pulse_frame_edge_locator_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [pfel_pkg::S_TDATA_W-1:0]      s_tdata,   // symbol, now_us, zero pad
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [pfel_pkg::M_TDATA_W-1:0]      m_tdata,   // edge_us, width_us, odd_pulses, zero pad
	output logic [1:0]                          m_tuser,   // status
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pfel_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pfel_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import pfel_pkg::*;

	// config registers
	logic [TICK_W-1:0]    tick_ns_q;
	logic [LIMIT_W-1:0]   min_width_q;
	logic [LIMIT_W-1:0]   max_width_q;
	logic [AGE_LIM_W-1:0] max_age_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_ns_q   <= TICK_NS_RST;
			min_width_q <= MIN_WIDTH_RST;
			max_width_q <= MAX_WIDTH_RST;
			max_age_q   <= MAX_AGE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TICK_NS:      tick_ns_q   <= cfg_data[TICK_W-1:0];
				CFG_MIN_WIDTH_US: min_width_q <= cfg_data[LIMIT_W-1:0];
				CFG_MAX_WIDTH_US: max_width_q <= cfg_data[LIMIT_W-1:0];
				CFG_MAX_AGE_US:   max_age_q   <= cfg_data[AGE_LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// stage valids and ready chain
	logic                  v_s1, v_s2, v_s3, v_out_q;
	logic [DIV_STAGES-1:0] v_div_q;
	logic                  rdy_s1, rdy_s2, rdy_s3, rdy_out;
	logic [DIV_STAGES-1:0] rdy_div;

	assign rdy_out = !v_out_q || m_tready;
	always_comb begin
		rdy_div[DIV_STAGES-1] = !v_div_q[DIV_STAGES-1] || rdy_out;
		for (int k = DIV_STAGES-2; k >= 0; k--) begin
			rdy_div[k] = !v_div_q[k] || rdy_div[k+1];
		end
	end
	assign rdy_s3   = !v_s3 || rdy_div[0];
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign s_tready = rdy_s1;

	// stage 1: duration products
	logic [PROD_W-1:0] d0_s1, d1_s1;
	logic              nz0_s1, nz1_s1, lv0_s1, lv1_s1, fe_s1;
	logic [NOW_W-1:0]  now_s1;
	logic [SYM_W-1:0]  sym;

	assign sym = s_tdata[SYM_W-1:0];

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			d0_s1  <= PROD_W'(sym[DUR_W-1:0]) * PROD_W'(tick_ns_q);
			d1_s1  <= PROD_W'(sym[16 +: DUR_W]) * PROD_W'(tick_ns_q);
			nz0_s1 <= |sym[DUR_W-1:0];
			nz1_s1 <= |sym[16 +: DUR_W];
			lv0_s1 <= sym[15];
			lv1_s1 <= sym[31];
			fe_s1  <= s_tlast;
			now_s1 <= s_tdata[SYM_W +: NOW_W];
		end
	end

	// stage 2: frame accumulators
	logic [ACC_W-1:0] elapsed_q, rise_q, high_q;
	logic             seen_q, prev_lvl_q;
	logic             rise0, rise1, lvl0, seen0, seen1, lvl1;
	logic [PROD_W-1:0] add0, add1;
	logic [DSUM_W-1:0] hinc, dsum;
	logic [ACC_W-1:0]  h_next, r_next, e_next, h_base;
	logic              xfer1;

	assign xfer1 = v_s1 && rdy_s2;

	always_comb begin
		rise0  = nz0_s1 && lv0_s1 && !prev_lvl_q;
		lvl0   = nz0_s1 ? lv0_s1 : prev_lvl_q;
		seen0  = seen_q || rise0;
		rise1  = nz1_s1 && lv1_s1 && !lvl0;
		seen1  = seen0 || rise1;
		lvl1   = nz1_s1 ? lv1_s1 : lvl0;
		add0   = (nz0_s1 && lv0_s1 && seen0) ? d0_s1 : '0;
		add1   = (nz1_s1 && lv1_s1 && seen1) ? d1_s1 : '0;
		// a rise in the second half restarts the high time after the first half
		hinc   = rise1 ? DSUM_W'(add1) : DSUM_W'(add0) + DSUM_W'(add1);
		h_base = (rise0 || rise1) ? '0 : high_q;
		h_next = h_base + ACC_W'(hinc);
		r_next = rise1 ? elapsed_q + ACC_W'(d0_s1) : (rise0 ? elapsed_q : rise_q);
		dsum   = DSUM_W'(d0_s1) + DSUM_W'(d1_s1);
		e_next = elapsed_q + ACC_W'(dsum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q  <= '0;
			rise_q     <= '0;
			high_q     <= '0;
			seen_q     <= 1'b0;
			prev_lvl_q <= 1'b0;
		end else if (xfer1) begin
			if (fe_s1) begin
				elapsed_q  <= '0;
				rise_q     <= '0;
				high_q     <= '0;
				seen_q     <= 1'b0;
				prev_lvl_q <= 1'b0;
			end else begin
				elapsed_q  <= e_next;
				rise_q     <= r_next;
				high_q     <= h_next;
				seen_q     <= seen1;
				prev_lvl_q <= lvl1;
			end
		end
	end

	logic [ACC_W-1:0] e_s2, r_s2, h_s2;
	logic             seen_s2;
	logic [NOW_W-1:0] now_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			e_s2    <= e_next;
			r_s2    <= r_next;
			h_s2    <= h_next;
			seen_s2 <= seen1;
			now_s2  <= now_s1;
		end
	end

	// stage 3: age in ns
	logic [ACC_W-1:0] age_ns_s3, h_s3;
	logic             seen_s3;
	logic [NOW_W-1:0] now_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			age_ns_s3 <= e_s2 - r_s2;
			h_s3      <= h_s2;
			seen_s3   <= seen_s2;
			now_s3    <= now_s2;
		end
	end

	// divider stages
	logic [ACC_W-1:0] width_q64, age_q64;
	logic             sd_seen_q [DIV_STAGES];
	logic [NOW_W-1:0] sd_now_q  [DIV_STAGES];

	pfel_div1000 u_div_width (
		.clk (clk),
		.adv (rdy_div),
		.x   (h_s3),
		.q   (width_q64)
	);

	pfel_div1000 u_div_age (
		.clk (clk),
		.adv (rdy_div),
		.x   (age_ns_s3),
		.q   (age_q64)
	);

	always_ff @(posedge clk) begin
		if (rdy_div[0]) begin
			sd_seen_q[0] <= seen_s3;
			sd_now_q[0]  <= now_s3;
		end
		for (int k = 1; k < DIV_STAGES; k++) begin
			if (rdy_div[k]) begin
				sd_seen_q[k] <= sd_seen_q[k-1];
				sd_now_q[k]  <= sd_now_q[k-1];
			end
		end
	end

	// result stage: gates and status
	logic [WIDTH_W-1:0] width_sat;
	logic               bad_width, too_old, seen_f;
	logic [NOW_W-1:0]   edge_calc;
	status_t            status_d, status_q;
	logic [NOW_W-1:0]   edge_q;
	logic [WIDTH_W-1:0] width_q;
	logic [ODD_W-1:0]   odd_q;
	logic               load_out;

	assign seen_f    = sd_seen_q[DIV_STAGES-1];
	assign width_sat = (|width_q64[ACC_W-1:WIDTH_W]) ? '1 : width_q64[WIDTH_W-1:0];
	assign bad_width = (width_sat < WIDTH_W'(min_width_q)) ||
	                   (width_sat > WIDTH_W'(max_width_q));
	assign too_old   = age_q64 > ACC_W'(max_age_q);
	assign edge_calc = sd_now_q[DIV_STAGES-1] - age_q64[NOW_W-1:0];
	assign load_out  = rdy_out && v_div_q[DIV_STAGES-1];

	always_comb begin
		if (!seen_f) begin
			status_d = ST_NO_EDGE;
		end else if (bad_width) begin
			status_d = ST_BAD_WIDTH;
		end else if (too_old) begin
			status_d = ST_TOO_OLD;
		end else begin
			status_d = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			edge_q   <= seen_f ? edge_calc : '0;
			width_q  <= seen_f ? width_sat : '0;
			status_q <= status_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			odd_q <= '0;
		end else if (load_out && status_d == ST_BAD_WIDTH) begin
			odd_q <= odd_q + 1'b1;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_div_q <= '0;
			v_out_q <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= s_tvalid;
			// only the frame's last symbol travels past the accumulators
			if (rdy_s2) v_s2 <= v_s1 && fe_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_div[0]) v_div_q[0] <= v_s3;
			for (int k = 1; k < DIV_STAGES; k++) begin
				if (rdy_div[k]) v_div_q[k] <= v_div_q[k-1];
			end
			if (rdy_out) v_out_q <= v_div_q[DIV_STAGES-1];
		end
	end

	assign m_tvalid = v_out_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {1'b0, odd_q, width_q, edge_q};

	// assertions
	a_no_edge_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_NO_EDGE) |-> (edge_q == '0 && width_q == '0))
		else $error("no-edge result carries nonzero edge or width");

	a_odd_step: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && status_d == ST_BAD_WIDTH) |=> (odd_q == $past(odd_q) + 1'b1))
		else $error("odd pulse count did not step on width reject");

	a_odd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(load_out && status_d == ST_BAD_WIDTH) |=> $stable(odd_q))
		else $error("odd pulse count changed without width reject");

	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer1 && fe_s1) |=> (elapsed_q == '0 && high_q == '0 && !seen_q && !prev_lvl_q))
		else $error("frame accumulators not cleared after frame end");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v_s1 && v_s2 && v_s3 && v_out_q))
		else $error("input stalled while a stage was empty");

endmodule
